// ===== design/pcm_codec_playback_regs_core_macros.svh =====
// Assertion macros for the codec playback core
`ifndef PCM_CODEC_PLAYBACK_REGS_CORE_MACROS_SVH
`define PCM_CODEC_PLAYBACK_REGS_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PCPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcpr assertion failed");
`define PCPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcpr assertion failed");
`else
`define PCPR_ASSERT_NOW(label, clk, rst, ante, cons)
`define PCPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/pcpr_pkg.sv =====
`timescale 1ns / 1ps

package pcpr_pkg;

   localparam int VOLUME_STEPS = 64;
   localparam int VOL_IDX_W    = $clog2(VOLUME_STEPS);
   localparam int NUM_REGS     = 16;
   localparam int REG_IDX_W    = $clog2(NUM_REGS);
   localparam int IRQ_LINES    = 16;
   localparam int IRQ_LINE_W   = $clog2(IRQ_LINES);

   typedef logic signed [15:0] sample_type;
   typedef logic [16:0]        gain_type;
   typedef logic [7:0]         byte_type;
   typedef logic signed [16:0] counter_type;

   // word kinds
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // bus ports
   localparam logic [1:0] PORT_INDEX  = 2'd0;
   localparam logic [1:0] PORT_DATA   = 2'd1;
   localparam logic [1:0] PORT_STATUS = 2'd2;
   localparam logic [1:0] PORT_UNUSED = 2'd3;

   // indexed registers
   localparam logic [REG_IDX_W-1:0] REG_LEFT_ATTEN  = 4'd6;
   localparam logic [REG_IDX_W-1:0] REG_RIGHT_ATTEN = 4'd7;
   localparam logic [REG_IDX_W-1:0] REG_FORMAT      = 4'd8;
   localparam logic [REG_IDX_W-1:0] REG_IFACE       = 4'd9;
   localparam logic [REG_IDX_W-1:0] REG_PIN_CTRL    = 4'd10;
   localparam logic [REG_IDX_W-1:0] REG_MODE_ID     = 4'd12;
   localparam logic [REG_IDX_W-1:0] REG_COUNT_HI    = 4'd14;
   localparam logic [REG_IDX_W-1:0] REG_COUNT_LO    = 4'd15;

   // sample formats, format register bits 6:4
   localparam logic [2:0] FMT_MONO8    = 3'd0;
   localparam logic [2:0] FMT_STEREO8  = 3'd1;
   localparam logic [2:0] FMT_MONO16   = 3'd4;
   localparam logic [2:0] FMT_STEREO16 = 3'd5;

   localparam byte_type PLAY_EN_MASK  = 8'h41;
   localparam byte_type PLAY_EN_VALUE = 8'h01;
   localparam byte_type FORMAT_MASK   = 8'h70;
   localparam byte_type STATUS_RESET  = 8'hcc;
   localparam byte_type ATTEN_MASK    = 8'h3f;
   localparam byte_type MUTE_BIT      = 8'h80;
   localparam byte_type SIGN_FLIP     = 8'h80;
   localparam byte_type STATUS_CLEAR  = 8'hfe;
   localparam byte_type PORT3_READ    = 8'hff;
   localparam byte_type ATTEN_RESET   = 8'h80;
   localparam byte_type IFACE_RESET   = 8'h08;
   localparam byte_type MODE_RESET    = 8'h0a;

   function automatic gain_type gain_lookup(input logic [VOL_IDX_W-1:0] step);
      gain_type g;
      case (step)
         6'd0:  g = 17'd65536;
         6'd1:  g = 17'd55141;
         6'd2:  g = 17'd46395;
         6'd3:  g = 17'd39037;
         6'd4:  g = 17'd32845;
         6'd5:  g = 17'd27636;
         6'd6:  g = 17'd23253;
         6'd7:  g = 17'd19565;
         6'd8:  g = 17'd16461;
         6'd9:  g = 17'd13850;
         6'd10: g = 17'd11654;
         6'd11: g = 17'd9805;
         6'd12: g = 17'd8250;
         6'd13: g = 17'd6941;
         6'd14: g = 17'd5840;
         6'd15: g = 17'd4914;
         6'd16: g = 17'd4135;
         6'd17: g = 17'd3479;
         6'd18: g = 17'd2927;
         6'd19: g = 17'd2463;
         6'd20: g = 17'd2072;
         6'd21: g = 17'd1743;
         6'd22: g = 17'd1467;
         6'd23: g = 17'd1234;
         6'd24: g = 17'd1038;
         6'd25: g = 17'd873;
         6'd26: g = 17'd735;
         6'd27: g = 17'd618;
         6'd28: g = 17'd520;
         6'd29: g = 17'd438;
         6'd30: g = 17'd368;
         6'd31: g = 17'd310;
         6'd32: g = 17'd260;
         6'd33: g = 17'd219;
         6'd34: g = 17'd184;
         6'd35: g = 17'd155;
         6'd36: g = 17'd130;
         6'd37: g = 17'd110;
         6'd38: g = 17'd92;
         6'd39: g = 17'd77;
         6'd40: g = 17'd65;
         6'd41: g = 17'd55;
         6'd42: g = 17'd46;
         6'd43: g = 17'd39;
         6'd44: g = 17'd32;
         6'd45: g = 17'd27;
         6'd46: g = 17'd23;
         6'd47: g = 17'd19;
         6'd48: g = 17'd16;
         6'd49: g = 17'd13;
         6'd50: g = 17'd11;
         6'd51: g = 17'd9;
         6'd52: g = 17'd8;
         6'd53: g = 17'd6;
         6'd54: g = 17'd5;
         6'd55: g = 17'd4;
         6'd56: g = 17'd4;
         6'd57: g = 17'd3;
         6'd58: g = 17'd2;
         6'd59: g = 17'd2;
         6'd60: g = 17'd2;
         6'd61: g = 17'd1;
         6'd62: g = 17'd1;
         6'd63: g = 17'd1;
         default: g = 17'd0;
      endcase
      return g;
   endfunction

endpackage

// ===== design/pcpr_ifs.sv =====
`timescale 1ns / 1ps

interface pcpr_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [1:0]          port;
   pcpr_pkg::byte_type  write_data;
   pcpr_pkg::byte_type  dma_byte0;
   pcpr_pkg::byte_type  dma_byte1;
   pcpr_pkg::byte_type  dma_byte2;
   pcpr_pkg::byte_type  dma_byte3;

   modport source (
      output valid, kind, port, write_data, dma_byte0, dma_byte1, dma_byte2, dma_byte3,
      input  ready
   );
   modport sink (
      input  valid, kind, port, write_data, dma_byte0, dma_byte1, dma_byte2, dma_byte3,
      output ready
   );
endinterface

interface pcpr_rsp_if;
   logic                  valid;
   logic                  ready;
   pcpr_pkg::byte_type    read_data;
   pcpr_pkg::sample_type  left_sample;
   pcpr_pkg::sample_type  right_sample;
   logic [2:0]            dma_bytes_used;
   logic [15:0]           irq_request_mask;

   modport source (
      output valid, read_data, left_sample, right_sample, dma_bytes_used, irq_request_mask,
      input  ready
   );
   modport sink (
      input  valid, read_data, left_sample, right_sample, dma_bytes_used, irq_request_mask,
      output ready
   );
endinterface

// ===== design/pcpr_atten.sv =====
`timescale 1ns / 1ps

module pcpr_atten (
   input  pcpr_pkg::sample_type sample_in,
   input  pcpr_pkg::byte_type   atten_reg,
   output pcpr_pkg::sample_type sample_out
);

   pcpr_pkg::gain_type  gain;
   logic signed [33:0]  product;
   logic                mute;

   assign mute    = (atten_reg & pcpr_pkg::MUTE_BIT) != 8'h00;
   assign gain    = pcpr_pkg::gain_lookup(atten_reg[pcpr_pkg::VOL_IDX_W-1:0]);
   assign product = 34'(sample_in) * 34'($signed({1'b0, gain}));

   // floor of product / 65536 always fits the sample range
   assign sample_out = mute ? 16'sd0 : product[31:16];

endmodule

// ===== design/pcm_codec_playback_regs_core.sv =====
`timescale 1ns / 1ps
// channel   | direction | payload
// req_chan  | in        | kind, port, write_data, dma_byte0..dma_byte3
// rsp_chan  | out       | read_data, left_sample, right_sample, dma_bytes_used,
//           |           | irq_request_mask
// csr_*     | in        | irq_line, 4 bits, written on csr_write_enable
//
// One word per cycle sustained while the result is not stalled. A word sits in
// an input register, then one pass of decode, unpack and one multiplier per
// channel updates the state and fills the result register. A stalled result
// holds both stages; the input side still takes a word while its register is
// empty. Synchronous reset restores valid flags and state, not data registers.

`include "pcm_codec_playback_regs_core_macros.svh"

module pcm_codec_playback_regs_core (
   input  logic                               clock,
   input  logic                               reset,
   pcpr_req_if.sink                           req_chan,
   pcpr_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [pcpr_pkg::IRQ_LINE_W-1:0]    csr_write_data
);

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_kind_ff;
   logic [1:0]            s1_port_ff;
   pcpr_pkg::byte_type    s1_wd_ff;
   pcpr_pkg::byte_type    s1_b0_ff, s1_b1_ff, s1_b2_ff, s1_b3_ff;
   logic                  advance;

   // block state
   logic [pcpr_pkg::IRQ_LINE_W-1:0] irq_line_ff;
   logic [pcpr_pkg::REG_IDX_W-1:0]  reg_index_ff, reg_index_in;
   logic                            trd_bit_ff, trd_bit_in;
   logic                            mode_change_bit_ff, mode_change_bit_in;
   pcpr_pkg::byte_type              idx_regs_ff [pcpr_pkg::NUM_REGS];
   pcpr_pkg::byte_type              idx_write_data;
   logic                            idx_write;
   pcpr_pkg::byte_type              status_reg_ff, status_reg_in;
   logic                            play_enable_ff, play_enable_in;
   pcpr_pkg::sample_type            left_out_ff, left_out_in;
   pcpr_pkg::sample_type            right_out_ff, right_out_in;
   pcpr_pkg::counter_type           sample_counter_ff, sample_counter_in;

   // result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   pcpr_pkg::byte_type    rsp_read_data_ff, rsp_read_data_in;
   logic [2:0]            rsp_used_ff, rsp_used_in;
   logic [15:0]           rsp_irq_ff, rsp_irq_in;

   // unpack and attenuation
   pcpr_pkg::sample_type  src_left, src_right;
   pcpr_pkg::sample_type  att_left, att_right;
   logic [2:0]            fmt;
   logic [2:0]            fmt_used;
   pcpr_pkg::counter_type counter_base;

   function automatic pcpr_pkg::counter_type counter_type_from_regs(
      input pcpr_pkg::byte_type hi,
      input pcpr_pkg::byte_type lo
   );
      return {1'b0, hi, lo};
   endfunction

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign s1_valid_in    = req_chan.ready ? req_chan.valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_kind_ff <= req_chan.kind;
         s1_port_ff <= req_chan.port;
         s1_wd_ff   <= req_chan.write_data;
         s1_b0_ff   <= req_chan.dma_byte0;
         s1_b1_ff   <= req_chan.dma_byte1;
         s1_b2_ff   <= req_chan.dma_byte2;
         s1_b3_ff   <= req_chan.dma_byte3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_line_ff <= '0;
      end else if (csr_write_enable) begin
         irq_line_ff <= csr_write_data;
      end
   end

   assign fmt = 3'((idx_regs_ff[pcpr_pkg::REG_FORMAT] & pcpr_pkg::FORMAT_MASK) >> 4);

   always_comb begin
      src_left  = left_out_ff;
      src_right = right_out_ff;
      fmt_used  = 3'd0;
      case (fmt)
         pcpr_pkg::FMT_MONO8: begin
            src_left  = {s1_b0_ff ^ pcpr_pkg::SIGN_FLIP, 8'h00};
            src_right = {s1_b0_ff ^ pcpr_pkg::SIGN_FLIP, 8'h00};
            fmt_used  = 3'd1;
         end
         pcpr_pkg::FMT_STEREO8: begin
            src_left  = {s1_b0_ff ^ pcpr_pkg::SIGN_FLIP, 8'h00};
            src_right = {s1_b1_ff ^ pcpr_pkg::SIGN_FLIP, 8'h00};
            fmt_used  = 3'd2;
         end
         pcpr_pkg::FMT_MONO16: begin
            src_left  = {s1_b1_ff, s1_b0_ff};
            src_right = {s1_b1_ff, s1_b0_ff};
            fmt_used  = 3'd2;
         end
         pcpr_pkg::FMT_STEREO16: begin
            src_left  = {s1_b1_ff, s1_b0_ff};
            src_right = {s1_b3_ff, s1_b2_ff};
            fmt_used  = 3'd4;
         end
         default: begin
            src_left  = left_out_ff;
            src_right = right_out_ff;
            fmt_used  = 3'd0;
         end
      endcase
   end

   pcpr_atten u_atten_left (
      .sample_in  (src_left),
      .atten_reg  (idx_regs_ff[pcpr_pkg::REG_LEFT_ATTEN]),
      .sample_out (att_left)
   );

   pcpr_atten u_atten_right (
      .sample_in  (src_right),
      .atten_reg  (idx_regs_ff[pcpr_pkg::REG_RIGHT_ATTEN]),
      .sample_out (att_right)
   );

   // reload when negative at the test, then count down
   assign counter_base = sample_counter_ff[16]
      ? counter_type_from_regs(idx_regs_ff[pcpr_pkg::REG_COUNT_HI],
                               idx_regs_ff[pcpr_pkg::REG_COUNT_LO])
      : sample_counter_ff;

   always_comb begin
      reg_index_in       = reg_index_ff;
      trd_bit_in         = trd_bit_ff;
      mode_change_bit_in = mode_change_bit_ff;
      status_reg_in      = status_reg_ff;
      play_enable_in     = play_enable_ff;
      left_out_in        = left_out_ff;
      right_out_in       = right_out_ff;
      sample_counter_in  = sample_counter_ff;
      idx_write          = 1'b0;
      idx_write_data     = s1_wd_ff;
      rsp_read_data_in   = 8'h00;
      rsp_used_in        = 3'd0;
      rsp_irq_in         = 16'h0000;
      case (s1_kind_ff)
         pcpr_pkg::KIND_READ: begin
            case (s1_port_ff)
               pcpr_pkg::PORT_INDEX: begin
                  rsp_read_data_in = {1'b0, mode_change_bit_ff, trd_bit_ff, 1'b0,
                                      reg_index_ff};
               end
               pcpr_pkg::PORT_DATA: begin
                  rsp_read_data_in = idx_regs_ff[reg_index_ff];
               end
               pcpr_pkg::PORT_STATUS: begin
                  rsp_read_data_in = status_reg_ff;
               end
               default: begin
                  rsp_read_data_in = pcpr_pkg::PORT3_READ;
               end
            endcase
         end
         pcpr_pkg::KIND_WRITE: begin
            case (s1_port_ff)
               pcpr_pkg::PORT_INDEX: begin
                  reg_index_in       = s1_wd_ff[3:0];
                  trd_bit_in         = s1_wd_ff[5];
                  mode_change_bit_in = s1_wd_ff[6];
               end
               pcpr_pkg::PORT_DATA: begin
                  if (reg_index_ff != pcpr_pkg::REG_MODE_ID) begin
                     idx_write = 1'b1;
                     if (reg_index_ff == pcpr_pkg::REG_IFACE) begin
                        play_enable_in = (s1_wd_ff & pcpr_pkg::PLAY_EN_MASK)
                                         == pcpr_pkg::PLAY_EN_VALUE;
                        if (!play_enable_in) begin
                           left_out_in  = 16'sd0;
                           right_out_in = 16'sd0;
                        end
                     end else if (reg_index_ff == pcpr_pkg::REG_COUNT_HI) begin
                        sample_counter_in = counter_type_from_regs(s1_wd_ff,
                           idx_regs_ff[pcpr_pkg::REG_COUNT_LO]);
                     end
                  end
               end
               pcpr_pkg::PORT_STATUS: begin
                  status_reg_in = status_reg_ff & pcpr_pkg::STATUS_CLEAR;
               end
               default: begin
                  status_reg_in = status_reg_ff;
               end
            endcase
         end
         pcpr_pkg::KIND_TICK: begin
            if (play_enable_ff) begin
               left_out_in       = att_left;
               right_out_in      = att_right;
               rsp_used_in       = fmt_used;
               sample_counter_in = counter_base - 17'sd1;
               if (sample_counter_ff[16] && !status_reg_ff[0]) begin
                  status_reg_in = status_reg_ff | 8'h01;
                  if (idx_regs_ff[pcpr_pkg::REG_PIN_CTRL][1]) begin
                     rsp_irq_in = 16'h0001 << irq_line_ff;
                  end
               end
            end else begin
               left_out_in  = 16'sd0;
               right_out_in = 16'sd0;
            end
         end
         default: begin
            rsp_read_data_in = 8'h00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_index_ff       <= '0;
         trd_bit_ff         <= 1'b0;
         mode_change_bit_ff <= 1'b1;
         status_reg_ff      <= pcpr_pkg::STATUS_RESET;
         play_enable_ff     <= 1'b0;
         left_out_ff        <= 16'sd0;
         right_out_ff       <= 16'sd0;
         sample_counter_ff  <= 17'sd0;
      end else if (advance) begin
         reg_index_ff       <= reg_index_in;
         trd_bit_ff         <= trd_bit_in;
         mode_change_bit_ff <= mode_change_bit_in;
         status_reg_ff      <= status_reg_in;
         play_enable_ff     <= play_enable_in;
         left_out_ff        <= left_out_in;
         right_out_ff       <= right_out_in;
         sample_counter_ff  <= sample_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pcpr_pkg::NUM_REGS; i++) begin
            if (i >= 2 && i <= 7) begin
               idx_regs_ff[i] <= pcpr_pkg::ATTEN_RESET;
            end else if (i == int'(pcpr_pkg::REG_IFACE)) begin
               idx_regs_ff[i] <= pcpr_pkg::IFACE_RESET;
            end else if (i == int'(pcpr_pkg::REG_MODE_ID)) begin
               idx_regs_ff[i] <= pcpr_pkg::MODE_RESET;
            end else begin
               idx_regs_ff[i] <= 8'h00;
            end
         end
      end else if (advance && idx_write) begin
         idx_regs_ff[reg_index_ff] <= idx_write_data;
      end
   end

   assign rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_used_ff      <= rsp_used_in;
         rsp_irq_ff       <= rsp_irq_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.read_data        = rsp_read_data_ff;
   assign rsp_chan.left_sample      = left_out_ff;
   assign rsp_chan.right_sample     = right_out_ff;
   assign rsp_chan.dma_bytes_used   = rsp_used_ff;
   assign rsp_chan.irq_request_mask = rsp_irq_ff;

   `PCPR_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff)
   `PCPR_ASSERT_NOW(a_irq_onehot, clock, reset, rsp_valid_ff, $onehot0(rsp_irq_ff))
   `PCPR_ASSERT_NOW(a_irq_status, clock, reset, rsp_valid_ff && rsp_irq_ff != 16'h0000, status_reg_ff[0])
   `PCPR_ASSERT_NOW(a_used_enabled, clock, reset, rsp_valid_ff && rsp_used_ff != 3'd0, play_enable_ff)
   `PCPR_ASSERT_NOW(a_counter_range, clock, reset, 1'b1, sample_counter_ff >= -17'sd1)

endmodule
